// ----- hw/rtl/fia_pkg.sv -----
// Package for the free interval ID allocator: widths, command and status codes.
// No dependencies.
package fia_pkg;
  localparam int unsigned IdBits       = 16;
  localparam int unsigned MaxIntervals = 16;
  localparam int unsigned OutBits      = 17;

  typedef enum logic [1:0] {
    CmdCheck   = 2'd0,
    CmdTake    = 2'd1,
    CmdRelease = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatIgnored = 2'd1,
    StatFull    = 2'd2
  } status_e;
endpackage

// ----- hw/rtl/fia_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on fia_pkg.
interface fia_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [fia_pkg::IdBits-1:0]  range_low;
  logic [fia_pkg::IdBits-1:0]  range_high;
  modport source (output valid, command, range_low, range_high, input ready);
  modport sink   (input valid, command, range_low, range_high, output ready);
endinterface

interface fia_res_if;
  logic                               valid;
  logic                               ready;
  logic                               range_is_free;
  logic [1:0]                         status;
  logic signed [fia_pkg::OutBits-1:0] lowest_free;
  logic signed [fia_pkg::OutBits-1:0] lowest_used;
  logic signed [fia_pkg::OutBits-1:0] highest_used;
  logic [4:0]                         interval_count;
  modport source (output valid, range_is_free, status, lowest_free, lowest_used,
                  highest_used, interval_count, input ready);
  modport sink   (input valid, range_is_free, status, lowest_free, lowest_used,
                  highest_used, interval_count, output ready);
endinterface

// ----- hw/rtl/free_interval_id_allocator_core.sv -----
// For a check or a trim, one sequencer walks the table of free intervals held (at most 16)
// one entry per cycle through a single compare unit to find the position, then decides, then
// forms the summary from the first and last entries. A take or release that opens or closes a
// slot adds shifting of the entries behind it, one entry per cycle, and a clear goes straight
// to the summary. The result word sits in an output register; the next command is accepted
// in the cycle after the result word is taken.
// Depends on fia_pkg and fia_if.
module free_interval_id_allocator_core (
  input  logic clk_i,
  input  logic rst_ni,
  fia_cmd_if.sink   cmd_i,
  fia_res_if.source res_o
);
  localparam int unsigned W  = fia_pkg::IdBits;
  localparam int unsigned N  = fia_pkg::MaxIntervals;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [W-1:0] MaxId = '1;

  typedef enum logic [2:0] {
    StIdle, StSearch, StDecide, StShiftUp, StShiftDn, StSum, StOut
  } state_e;

  state_e          state_q;
  logic [W-1:0]    st_q [N];
  logic [W-1:0]    en_q [N];
  logic [CW-1:0]   tot_q;
  logic [1:0]      cmd_q;
  logic [W-1:0]    lo_q, hi_q;
  logic [CW-1:0]   idx_q, pos_q, hold_q;
  logic            ovl_q, found_q;
  logic [CW-1:0]   k_q;
  logic [W-1:0]    ins_s_q, ins_e_q;

  logic [AW-1:0]   ia;
  logic            in_lo, ovl_c, le_hi;
  assign ia    = idx_q[AW-1:0];
  assign in_lo = (st_q[ia] <= lo_q) && (en_q[ia] >= lo_q);
  assign ovl_c = (st_q[ia] <= hi_q) && (en_q[ia] >= lo_q);
  assign le_hi = st_q[ia] <= hi_q;

  logic [W-1:0] lo_in, hi_in;
  assign lo_in = (cmd_i.range_low > cmd_i.range_high) ? cmd_i.range_high : cmd_i.range_low;
  assign hi_in = (cmd_i.range_low > cmd_i.range_high) ? cmd_i.range_low : cmd_i.range_high;

  assign cmd_i.ready = (state_q == StIdle);
  assign res_o.valid = (state_q == StOut);

  logic [AW-1:0] ha, pa, pm, ka, km, kp;
  assign ha = hold_q[AW-1:0];
  assign pa = pos_q[AW-1:0];
  assign pm = AW'(pos_q - 1'b1);
  assign ka = k_q[AW-1:0];
  assign km = AW'(k_q - 1'b1);
  assign kp = AW'(k_q + 1'b1);

  logic [AW-1:0] la;
  assign la = AW'(tot_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tot_q   <= CW'(1);
      st_q[0] <= '0;
      en_q[0] <= MaxId;
      res_o.range_is_free <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (cmd_i.valid) begin
          cmd_q <= cmd_i.command; lo_q <= lo_in; hi_q <= hi_in;
          idx_q <= '0; pos_q <= '0; ovl_q <= 1'b0; found_q <= 1'b0;
          res_o.status <= fia_pkg::StatDone;
          res_o.range_is_free <= 1'b0;
          if (fia_pkg::cmd_e'(cmd_i.command) == fia_pkg::CmdClear) begin
            tot_q <= CW'(1); st_q[0] <= '0; en_q[0] <= MaxId;
            state_q <= StSum;
          end else begin
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (idx_q >= tot_q) begin
            state_q <= StDecide;
          end else begin
            if (in_lo && !found_q) begin
              found_q <= 1'b1; hold_q <= idx_q;
            end
            if (ovl_c) ovl_q <= 1'b1;
            if (le_hi) pos_q <= idx_q + 1'b1;
            idx_q <= idx_q + 1'b1;
          end
        end
        StDecide: begin
          state_q <= StSum;
          case (fia_pkg::cmd_e'(cmd_q))
            fia_pkg::CmdCheck:
              res_o.range_is_free <= found_q && (en_q[ha] >= hi_q);
            fia_pkg::CmdTake: begin
              if (!found_q || en_q[ha] < hi_q) begin
                res_o.status <= fia_pkg::StatIgnored;
              end else if (st_q[ha] == lo_q && en_q[ha] == hi_q) begin
                k_q <= hold_q; state_q <= StShiftDn;
              end else if (st_q[ha] == lo_q) begin
                st_q[ha] <= hi_q + 1'b1;
              end else if (en_q[ha] == hi_q) begin
                en_q[ha] <= lo_q - 1'b1;
              end else if (tot_q >= CW'(N)) begin
                res_o.status <= fia_pkg::StatFull;
              end else begin
                ins_s_q <= hi_q + 1'b1; ins_e_q <= en_q[ha];
                en_q[ha] <= lo_q - 1'b1;
                pos_q <= hold_q + 1'b1; k_q <= tot_q;
                state_q <= StShiftUp;
              end
            end
            fia_pkg::CmdRelease: begin
              logic jl, jr;
              jl = (pos_q != '0) && (en_q[pm] + 1'b1 == lo_q) && (en_q[pm] != MaxId);
              jr = (pos_q < tot_q) && (st_q[pa] == hi_q + 1'b1) && (hi_q != MaxId);
              if (ovl_q) begin
                res_o.status <= fia_pkg::StatIgnored;
              end else if (jl && jr) begin
                en_q[pm] <= en_q[pa]; k_q <= pos_q; state_q <= StShiftDn;
              end else if (jl) begin
                en_q[pm] <= hi_q;
              end else if (jr) begin
                st_q[pa] <= lo_q;
              end else if (tot_q >= CW'(N)) begin
                res_o.status <= fia_pkg::StatFull;
              end else begin
                ins_s_q <= lo_q; ins_e_q <= hi_q; k_q <= tot_q;
                state_q <= StShiftUp;
              end
            end
            default: ;
          endcase
        end
        StShiftUp: begin
          // Move entries up one place, top first, then drop the new one into the gap.
          if (k_q > pos_q) begin
            st_q[ka] <= st_q[km]; en_q[ka] <= en_q[km]; k_q <= k_q - 1'b1;
          end else begin
            st_q[pa] <= ins_s_q; en_q[pa] <= ins_e_q;
            tot_q <= tot_q + 1'b1; state_q <= StSum;
          end
        end
        StShiftDn: begin
          if (k_q + 1'b1 < tot_q) begin
            st_q[ka] <= st_q[kp]; en_q[ka] <= en_q[kp]; k_q <= k_q + 1'b1;
          end else begin
            tot_q <= tot_q - 1'b1; state_q <= StSum;
          end
        end
        StSum: begin
          res_o.interval_count <= 5'(tot_q);
          if (tot_q == '0) begin
            res_o.lowest_free  <= '1;
            res_o.lowest_used  <= '0;
            res_o.highest_used <= {1'b0, MaxId};
          end else begin
            res_o.lowest_free <= {1'b0, st_q[0]};
            if (st_q[0] != '0) res_o.lowest_used <= '0;
            else if (en_q[0] != MaxId) res_o.lowest_used <= {1'b0, en_q[0] + 1'b1};
            else res_o.lowest_used <= '1;
            if (en_q[la] != MaxId) res_o.highest_used <= {1'b0, MaxId};
            else if (st_q[la] != '0) res_o.highest_used <= {1'b0, st_q[la] - 1'b1};
            else res_o.highest_used <= '1;
          end
          state_q <= StOut;
        end
        StOut: if (res_o.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/fia_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
// Depends on fia_pkg.
module fia_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [4:0] count_i
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready right after a command");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= fia_pkg::StatFull) else $error("bad status");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= 5'(fia_pkg::MaxIntervals)) else $error("count too big");
endmodule

bind free_interval_id_allocator_core fia_checker u_fia_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(cmd_i.valid), .in_ready_i(cmd_i.ready),
  .out_valid_i(res_o.valid), .out_ready_i(res_o.ready),
  .status_i(res_o.status), .count_i(res_o.interval_count));
